### hw/rtl/http_chunked_body_decoder_defines.svh
// Assertion helpers shared by the RTL. They sample on aclk and are
// disabled while aresetn is low.
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// Same-cycle implication.
`define HCBD_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HCBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/hcbd_pkg.sv
package hcbd_pkg;

    localparam int SIZE_BITS  = 22;
    localparam int LINE_LIMIT = 32;
    localparam int COUNT_BITS = 22;
    localparam int LEN_W      = $clog2(LINE_LIMIT + 2);

    localparam logic [LEN_W-1:0]      LINE_LIMIT_LEN = LEN_W'(LINE_LIMIT);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX      = '1;

    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;

    typedef enum logic [2:0] {
        PH_HEX,
        PH_EXT,
        PH_DATA,
        PH_CR,
        PH_LF,
        PH_DONE,
        PH_ERR
    } phase_t;

    typedef enum logic [1:0] {
        ST_BUSY,
        ST_OK,
        ST_ERR
    } status_t;

    typedef struct packed {
        phase_t                 phase;
        logic [SIZE_BITS-1:0]   chunk_size;
        logic [SIZE_BITS-1:0]   bytes_left;
        logic [LEN_W-1:0]       line_length;
        logic                   digit_seen;
        logic                   pending_cr;
        logic [COUNT_BITS-1:0]  emitted_count;
    } hcbd_state_t;

    typedef struct packed {
        logic [7:0]             data_byte;
        logic                   data_valid;
        status_t                status;
        logic [COUNT_BITS-1:0]  count;
    } hcbd_result_t;

    localparam hcbd_state_t STATE_RESET = '{
        phase:         PH_HEX,
        chunk_size:    '0,
        bytes_left:    '0,
        line_length:   '0,
        digit_seen:    1'b0,
        pending_cr:    1'b0,
        emitted_count: '0
    };

    // bit 4: is a hex digit, bits 3:0: its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

### hw/rtl/hcbd_step.sv
module hcbd_step (
    input  hcbd_pkg::hcbd_state_t  cur,
    input  logic [7:0]             in_byte,
    input  logic                   in_last,
    output hcbd_pkg::hcbd_state_t  nxt,
    output hcbd_pkg::hcbd_result_t res
);

    hcbd_pkg::phase_t                p1;
    logic [hcbd_pkg::LEN_W-1:0]      len1;
    logic [hcbd_pkg::LEN_W-1:0]      len2;
    logic [4:0]                      hd;
    logic [hcbd_pkg::SIZE_BITS+3:0]  grown;

    always_comb begin
        nxt            = cur;
        res.data_byte  = 8'h00;
        res.data_valid = 1'b0;
        p1             = cur.phase;
        len1           = cur.line_length;
        len2           = cur.line_length;
        hd             = hcbd_pkg::hex_digit(in_byte);
        grown          = {cur.chunk_size, hd[3:0]};

        case (cur.phase)
            hcbd_pkg::PH_HEX, hcbd_pkg::PH_EXT: begin
                if (cur.pending_cr && in_byte == hcbd_pkg::CH_LF) begin
                    nxt.pending_cr = 1'b0;
                    if (cur.phase == hcbd_pkg::PH_HEX && !cur.digit_seen) begin
                        nxt.phase = hcbd_pkg::PH_ERR;
                    end else if (cur.chunk_size == '0) begin
                        nxt.phase = hcbd_pkg::PH_DONE;
                    end else begin
                        nxt.bytes_left = cur.chunk_size;
                        nxt.phase      = hcbd_pkg::PH_DATA;
                    end
                end else begin
                    // lone CR is line content
                    if (cur.pending_cr) begin
                        len1 = cur.line_length + hcbd_pkg::LEN_W'(1);
                        if (len1 >= hcbd_pkg::LINE_LIMIT_LEN
                            || cur.phase == hcbd_pkg::PH_HEX) begin
                            p1 = hcbd_pkg::PH_ERR;
                        end
                    end
                    nxt.phase       = p1;
                    nxt.line_length = len1;
                    nxt.pending_cr  = 1'b0;
                    if (p1 inside {hcbd_pkg::PH_HEX, hcbd_pkg::PH_EXT}) begin
                        if (in_byte == hcbd_pkg::CH_CR) begin
                            nxt.pending_cr = 1'b1;
                        end else begin
                            len2            = len1 + hcbd_pkg::LEN_W'(1);
                            nxt.line_length = len2;
                            if (len2 >= hcbd_pkg::LINE_LIMIT_LEN) begin
                                nxt.phase = hcbd_pkg::PH_ERR;
                            end else if (p1 == hcbd_pkg::PH_EXT) begin
                                nxt.phase = hcbd_pkg::PH_EXT;
                            end else if (in_byte == hcbd_pkg::CH_SEMI) begin
                                nxt.phase = cur.digit_seen ? hcbd_pkg::PH_EXT
                                                           : hcbd_pkg::PH_ERR;
                            end else if (!hd[4]) begin
                                nxt.phase = hcbd_pkg::PH_ERR;
                            end else begin
                                nxt.chunk_size = grown[hcbd_pkg::SIZE_BITS-1:0];
                                nxt.digit_seen = 1'b1;
                                if (grown[hcbd_pkg::SIZE_BITS+3 -: 4] != 4'h0) begin
                                    nxt.phase = hcbd_pkg::PH_ERR;
                                end
                            end
                        end
                    end
                end
            end
            hcbd_pkg::PH_DATA: begin
                res.data_valid = 1'b1;
                res.data_byte  = in_byte;
                if (cur.emitted_count != hcbd_pkg::COUNT_MAX) begin
                    nxt.emitted_count = cur.emitted_count + hcbd_pkg::COUNT_BITS'(1);
                end
                if (cur.bytes_left != '0) begin
                    nxt.bytes_left = cur.bytes_left - hcbd_pkg::SIZE_BITS'(1);
                end
                if (cur.bytes_left <= hcbd_pkg::SIZE_BITS'(1)) begin
                    nxt.phase = hcbd_pkg::PH_CR;
                end
            end
            hcbd_pkg::PH_CR: begin
                nxt.phase = (in_byte == hcbd_pkg::CH_CR) ? hcbd_pkg::PH_LF
                                                         : hcbd_pkg::PH_ERR;
            end
            hcbd_pkg::PH_LF: begin
                if (in_byte == hcbd_pkg::CH_LF) begin
                    nxt.phase       = hcbd_pkg::PH_HEX;
                    nxt.chunk_size  = '0;
                    nxt.line_length = '0;
                    nxt.digit_seen  = 1'b0;
                    nxt.pending_cr  = 1'b0;
                end else begin
                    nxt.phase = hcbd_pkg::PH_ERR;
                end
            end
            hcbd_pkg::PH_DONE: begin
                nxt.phase = hcbd_pkg::PH_DONE;
            end
            default: begin
                nxt.phase = hcbd_pkg::PH_ERR;
            end
        endcase

        // body ended before the terminating chunk
        if (in_last && nxt.phase != hcbd_pkg::PH_DONE) begin
            nxt.phase = hcbd_pkg::PH_ERR;
        end

        if (nxt.phase == hcbd_pkg::PH_DONE) begin
            res.status = hcbd_pkg::ST_OK;
        end else if (nxt.phase == hcbd_pkg::PH_ERR) begin
            res.status = hcbd_pkg::ST_ERR;
        end else begin
            res.status = hcbd_pkg::ST_BUSY;
        end
        res.count = nxt.emitted_count;

        if (in_last) begin
            nxt = hcbd_pkg::STATE_RESET;
        end
    end

endmodule

### hw/rtl/http_chunked_body_decoder.sv
// Chunked HTTP body decoder.
// Input stream: one raw body byte per transfer on s_tdata[7:0]; s_tlast marks
// the final byte of a body. Every input transfer yields exactly one output
// transfer: m_tdata carries the byte (valid only when m_tuser[0] is set) and
// the running payload count, m_tuser[2:1] the status (0 busy, 1 terminating
// zero chunk seen, 2 malformed or truncated).
// A byte's result is registered and reaches the master side in the cycle
// after its transfer. Throughput: one byte per cycle while m_tready is high;
// the whole per-byte decode sits between parser state and output registers.
// Backpressure: s_tready is high while the output register is empty or being
// drained, so a byte is still accepted while a result waits if m_tready is
// high in that cycle. With m_tready low and a result held, input stalls.
// Reset (aresetn low, synchronous): parser returns to expecting a size line,
// count cleared, output register empty. After the transfer marked last the
// parser returns to the same state for the next body.
`include "http_chunked_body_decoder_defines.svh"

module http_chunked_body_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic [31:0] m_tdata,   // [7:0] out_byte, [29:8] payload_count, [31:30] zero
    output logic [2:0]  m_tuser,   // [0] out_valid, [2:1] decode_status
    output logic        m_tvalid,
    input  logic        m_tready
);

    hcbd_pkg::hcbd_state_t  state_reg;
    hcbd_pkg::hcbd_state_t  state_next;
    hcbd_pkg::hcbd_result_t result_reg;
    hcbd_pkg::hcbd_result_t result_next;
    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic                   s_accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    hcbd_step u_step (
        .cur     (state_reg),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .nxt     (state_next),
        .res     (result_next)
    );

    always_comb begin
        if (s_accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= hcbd_pkg::STATE_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (s_accept) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, result_reg.count, result_reg.data_byte};
    assign m_tuser  = {result_reg.status, result_reg.data_valid};

    `HCBD_ASSERT(a_data_has_bytes, state_reg.phase == hcbd_pkg::PH_DATA, state_reg.bytes_left != '0, "data phase with no bytes left")
    `HCBD_ASSERT(a_line_short, (state_reg.phase == hcbd_pkg::PH_HEX) || (state_reg.phase == hcbd_pkg::PH_EXT), state_reg.line_length < hcbd_pkg::LINE_LIMIT_LEN, "size line over limit")
    `HCBD_ASSERT_NEXT(a_last_restarts, s_accept && s_tlast, state_reg == hcbd_pkg::STATE_RESET, "parser not restarted after last")
    `HCBD_ASSERT(a_ok_no_data, m_tvalid_reg && result_reg.status == hcbd_pkg::ST_OK, !result_reg.data_valid, "payload byte after end of body")

endmodule

### sim/chunk_decode_checker.sv
`timescale 1ns / 100ps

module chunk_decode_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    output int          fail_count,
    output int          pending_count,
    output int          checked_count
);

    localparam logic [31:0] SIZE_LIMIT = (32'd1 << hcbd_pkg::SIZE_BITS) - 32'd1;

    typedef struct packed {
        logic [7:0]                      data;
        logic                            valid;
        hcbd_pkg::status_t               status;
        logic [hcbd_pkg::COUNT_BITS-1:0] count;
    } decoded_t;

    decoded_t                        expected_q[$];
    hcbd_pkg::phase_t                ph;
    logic [31:0]                     size_acc;
    logic [31:0]                     remaining;
    int                              line_len;
    bit                              have_digit;
    bit                              cr_held;
    logic [hcbd_pkg::COUNT_BITS-1:0] payload_total;

    task automatic begin_size_line();
        ph = hcbd_pkg::PH_HEX;
        size_acc = '0;
        line_len = 0;
        have_digit = 1'b0;
        cr_held = 1'b0;
    endtask

    task automatic clear_body();
        begin_size_line();
        remaining = '0;
        payload_total = '0;
    endtask

    // one content byte of a size line, CR LF excluded
    task automatic size_line_char(input logic [7:0] c);
        logic [3:0] nib;
        line_len++;
        if (line_len >= hcbd_pkg::LINE_LIMIT) begin
            ph = hcbd_pkg::PH_ERR;
            return;
        end
        if (ph == hcbd_pkg::PH_EXT) return;
        if (c == hcbd_pkg::CH_SEMI) begin
            ph = have_digit ? hcbd_pkg::PH_EXT : hcbd_pkg::PH_ERR;
            return;
        end
        if (c >= "0" && c <= "9") begin
            nib = 4'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            nib = 4'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "F") begin
            nib = 4'(c - "A" + 8'd10);
        end else begin
            ph = hcbd_pkg::PH_ERR;
            return;
        end
        size_acc = (size_acc << 4) | 32'(nib);
        have_digit = 1'b1;
        if (size_acc > SIZE_LIMIT) ph = hcbd_pkg::PH_ERR;
    endtask

    task automatic size_line_byte(input logic [7:0] c);
        if (cr_held && c == hcbd_pkg::CH_LF) begin
            cr_held = 1'b0;
            if (ph == hcbd_pkg::PH_HEX && !have_digit) begin
                ph = hcbd_pkg::PH_ERR;
            end else if (size_acc == 0) begin
                ph = hcbd_pkg::PH_DONE;
            end else begin
                remaining = size_acc;
                ph = hcbd_pkg::PH_DATA;
            end
        end else begin
            // a CR without LF is ordinary line content
            if (cr_held) begin
                cr_held = 1'b0;
                size_line_char(hcbd_pkg::CH_CR);
            end
            if (ph == hcbd_pkg::PH_HEX || ph == hcbd_pkg::PH_EXT) begin
                if (c == hcbd_pkg::CH_CR) cr_held = 1'b1;
                else size_line_char(c);
            end
        end
    endtask

    task automatic decode_byte(input logic [7:0] c, input logic last);
        decoded_t r;
        r.data = '0;
        r.valid = 1'b0;
        case (ph)
            hcbd_pkg::PH_HEX, hcbd_pkg::PH_EXT: size_line_byte(c);
            hcbd_pkg::PH_DATA: begin
                r.valid = 1'b1;
                r.data = c;
                if (payload_total != hcbd_pkg::COUNT_MAX) payload_total++;
                if (remaining != 0) remaining--;
                if (remaining == 0) ph = hcbd_pkg::PH_CR;
            end
            hcbd_pkg::PH_CR: ph = (c == hcbd_pkg::CH_CR) ? hcbd_pkg::PH_LF : hcbd_pkg::PH_ERR;
            hcbd_pkg::PH_LF: begin
                if (c == hcbd_pkg::CH_LF) begin_size_line();
                else ph = hcbd_pkg::PH_ERR;
            end
            hcbd_pkg::PH_DONE: ;
            default: ph = hcbd_pkg::PH_ERR;
        endcase
        if (last && ph != hcbd_pkg::PH_DONE) ph = hcbd_pkg::PH_ERR;
        if (ph == hcbd_pkg::PH_DONE) begin
            r.status = hcbd_pkg::ST_OK;
        end else if (ph == hcbd_pkg::PH_ERR) begin
            r.status = hcbd_pkg::ST_ERR;
        end else begin
            r.status = hcbd_pkg::ST_BUSY;
        end
        r.count = payload_total;
        expected_q.push_back(r);
        if (last) clear_body();
    endtask

    task automatic compare_result();
        decoded_t want;
        checked_count++;
        if (expected_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("ERROR %0t: unexpected transfer tdata=%h tuser=%h",
                         $time, m_tdata, m_tuser);
            return;
        end
        want = expected_q.pop_front();
        if (m_tdata[7:0] !== want.data || m_tuser[0] !== want.valid ||
            m_tuser[2:1] !== want.status || m_tdata[29:8] !== want.count) begin
            fail_count++;
            if (fail_count <= 10) begin
                $write("ERROR %0t: result %0d expected byte=%h valid=%b status=%0d count=%0d",
                       $time, checked_count, want.data, want.valid, want.status,
                       want.count);
                $display(", got byte=%h valid=%b status=%0d count=%0d",
                         m_tdata[7:0], m_tuser[0], m_tuser[2:1], m_tdata[29:8]);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_q.delete();
            clear_body();
            pending_count <= 0;
        end else begin
            if (m_tvalid && m_tready) compare_result();
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
            pending_count <= expected_q.size();
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int ITEM_TARGET  = 1950;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } in_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    int         fail_count;
    int         pending_count;
    int         checked_count;
    int         cycle_count;
    int         send_idle_pct;
    int         stall_pct;
    int         body_count;
    int         directed_items;
    in_beat_t   stim_q[$];
    logic [7:0] body_buf[$];

    always #5 aclk = ~aclk;

    http_chunked_body_decoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    chunk_decode_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) body_buf.push_back(s[i]);
    endtask

    task automatic put_crlf();
        body_buf.push_back(hcbd_pkg::CH_CR);
        body_buf.push_back(hcbd_pkg::CH_LF);
    endtask

    task automatic flush_body();
        for (int i = 0; i < body_buf.size(); i++)
            stim_q.push_back('{body_buf[i], i == body_buf.size() - 1});
        body_buf.delete();
        body_count++;
    endtask

    // hex size, optional leading zeros, mixed case, optional extension
    task automatic put_size_line(input int unsigned size);
        string      digits;
        logic [7:0] c;
        int         ext_len;
        digits = $sformatf("%0h", size);
        if ($urandom_range(7) == 0) repeat ($urandom_range(1, 2)) body_buf.push_back("0");
        for (int i = 0; i < digits.len(); i++) begin
            c = digits[i];
            if (c >= "a" && $urandom_range(1) == 1) c = c - 8'h20;
            body_buf.push_back(c);
        end
        if ($urandom_range(3) == 0) begin
            body_buf.push_back(hcbd_pkg::CH_SEMI);
            ext_len = ($urandom_range(24) == 0) ? $urandom_range(28, 40) : $urandom_range(12);
            repeat (ext_len) begin
                c = 8'($urandom_range(255));
                body_buf.push_back(c == hcbd_pkg::CH_LF ? 8'h78 : c);
            end
        end
        put_crlf();
    endtask

    task automatic put_random_body();
        int unsigned kind;
        int unsigned r;
        int unsigned n;
        int unsigned pos;
        kind = $urandom_range(99);
        if (kind >= 90) begin
            repeat ($urandom_range(1, 20)) body_buf.push_back(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(3)) begin
                r = $urandom_range(99);
                n = (r < 60) ? $urandom_range(1, 8) :
                    (r < 90) ? $urandom_range(9, 40) :
                    (r < 98) ? $urandom_range(41, 120) : $urandom_range(200, 400);
                put_size_line(n);
                repeat (n) body_buf.push_back(8'($urandom_range(255)));
                put_crlf();
            end
            put_size_line(0);
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 3)) body_buf.push_back(8'($urandom_range(255)));
            if (kind >= 70) begin
                pos = $urandom_range(body_buf.size() - 1);
                case ($urandom_range(3))
                    0: body_buf[pos] = 8'($urandom_range(255));
                    1: while (body_buf.size() > pos + 1) void'(body_buf.pop_back());
                    2: body_buf.insert(pos, 8'($urandom_range(255)));
                    default: begin
                        // oversized value or a line of 31 to 40 zeros (over the limit from 32)
                        body_buf.delete();
                        if ($urandom_range(1) == 1)
                            put_text($sformatf("%h", $urandom_range(32'hFFFFFFFF, 32'h400000)));
                        else
                            repeat ($urandom_range(31, 40)) body_buf.push_back("0");
                        put_crlf();
                    end
                endcase
            end
        end
        flush_body();
    endtask

    initial begin
        int idx;
        int flow;
        int next_flow;
        int span;

        put_text("0");
        put_crlf();
        flush_body();
        // lone CR inside extension, extreme data bytes
        put_text("2;");
        body_buf.push_back(hcbd_pkg::CH_CR);
        put_crlf();
        body_buf.push_back(8'h00);
        body_buf.push_back(8'hFF);
        put_crlf();
        put_text("0");
        put_crlf();
        flush_body();
        // lone CR before the size ends
        put_text("1");
        body_buf.push_back(hcbd_pkg::CH_CR);
        put_text("-");
        flush_body();
        put_text("400000");
        flush_body();
        // missing CR after chunk data
        put_text("1");
        put_crlf();
        put_text("Ax");
        flush_body();
        directed_items = stim_q.size();
        while (stim_q.size() < ITEM_TARGET) put_random_body();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        idx = 0;
        flow = 0;
        span = stim_q.size() - directed_items;
        while (idx < stim_q.size()) begin
            @(posedge aclk);
            if (s_tvalid && s_tready) idx++;
            if (!s_tvalid || s_tready) begin
                if (idx < stim_q.size()) begin
                    next_flow = (idx < directed_items) ? 0 : ((idx - directed_items) * 4) / span;
                    if (next_flow != flow) begin
                        // hold off until the decoder has delivered everything
                        s_tvalid <= 1'b0;
                        do @(posedge aclk); while (pending_count != 0);
                        flow = next_flow;
                        send_idle_pct = (flow == 1) ? 46 : (flow == 3) ? 8 : 0;
                        stall_pct = (flow == 2) ? 46 : (flow == 3) ? 8 : 0;
                    end
                    if ($urandom_range(99) < send_idle_pct) begin
                        s_tvalid <= 1'b0;
                    end else begin
                        s_tvalid <= 1'b1;
                        s_tdata <= stim_q[idx].b;
                        s_tlast <= stim_q[idx].last;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end

        stall_pct = 0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Summary: %0d bytes in %0d bodies (%0d directed), %0d results checked, %0d bad",
                 stim_q.size(), body_count, directed_items, checked_count, fail_count);
        $display("Flow control: none, sender gaps, receiver stalls, both; drained between.");
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/hcbd_pkg.sv
hw/rtl/hcbd_step.sv
hw/rtl/http_chunked_body_decoder.sv
sim/chunk_decode_checker.sv
sim/tb_top.sv
